// ===== rtl/core/mpq_pkg.sv =====
// Shared types and codes for the minimum priority queue.
// No dependencies; used by mpq_cell and min_priority_queue.
package mpq_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned PriW  = 32;
    localparam int unsigned HeldW = 5;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_PEEK   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef logic signed [DataW-1:0] t_data;
    typedef logic signed [PriW-1:0]  t_pri;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     occupied;   // cell holds a live entry
        logic     tail;       // first free cell
    } t_cell_ctl;

endpackage

// ===== rtl/core/mpq_cell.sv =====
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on mpq_pkg.
module mpq_cell (
    input  logic                i_clk,
    input  mpq_pkg::t_cell_ctl  i_ctl,
    input  mpq_pkg::t_data      i_new_data,
    input  mpq_pkg::t_pri       i_new_pri,
    input  mpq_pkg::t_data      i_left_data,
    input  mpq_pkg::t_pri       i_left_pri,
    input  logic                i_left_shift,
    input  mpq_pkg::t_data      i_right_data,
    input  mpq_pkg::t_pri       i_right_pri,
    output mpq_pkg::t_data      o_data,
    output mpq_pkg::t_pri       o_pri,
    output logic                o_shift
);

    mpq_pkg::t_data r_data;
    mpq_pkg::t_pri  r_pri;
    mpq_pkg::t_data n_data;
    mpq_pkg::t_pri  n_pri;
    logic           take;

    // Strict compare keeps equal priorities in arrival order.
    assign o_shift = i_ctl.occupied && (i_new_pri < r_pri);
    assign take    = o_shift || i_ctl.tail;

    always_comb begin
        n_data = r_data;
        n_pri  = r_pri;
        unique case (i_ctl.op)
            mpq_pkg::CELL_INSERT: begin
                if (take) begin
                    if (i_left_shift) begin
                        n_data = i_left_data;
                        n_pri  = i_left_pri;
                    end else begin
                        n_data = i_new_data;
                        n_pri  = i_new_pri;
                    end
                end
            end
            mpq_pkg::CELL_DELETE: begin
                n_data = i_right_data;
                n_pri  = i_right_pri;
            end
            default: begin
                n_data = r_data;
                n_pri  = r_pri;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_pri  <= n_pri;
    end

    assign o_data = r_data;
    assign o_pri  = r_pri;

endmodule

// ===== rtl/core/min_priority_queue.sv =====
// Top level of the bounded minimum priority queue: command register, fill count,
// sorted chain of mpq_cell slots and result register. Depends on mpq_pkg, mpq_cell.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_action, i_new_data, i_new_priority
//  out     | output    | o_out_valid / i_out_ready | o_status, o_out_data, o_out_priority,
//          |           |                           | o_held_count
//
// Each item goes through the command register first; the cell chain then updates
// and the result register loads together. The chain keeps entries sorted,
// so the minimum always sits in cell 0 and no search is needed.
// A new item is taken while a result waits; the command then holds until the
// result register frees. Synchronous active-low reset clears fill count, busy and valid.
module min_priority_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_action,
    input  logic signed [31:0]           i_new_data,
    input  logic signed [31:0]           i_new_priority,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_status,
    output logic signed [31:0]           o_out_data,
    output logic signed [31:0]           o_out_priority,
    output logic [mpq_pkg::HeldW-1:0]    o_held_count
);

    localparam int unsigned CntW = $clog2(DEPTH + 1);

    logic                 r_busy;
    logic [1:0]           r_act;
    mpq_pkg::t_data       r_new_data;
    mpq_pkg::t_pri        r_new_pri;
    logic [CntW-1:0]      r_count;
    logic [CntW-1:0]      n_count;
    logic                 r_ovalid;
    logic [1:0]           r_status;
    mpq_pkg::t_data       r_odata;
    mpq_pkg::t_pri        r_opri;
    logic [1:0]           n_status;
    mpq_pkg::t_data       n_odata;
    mpq_pkg::t_pri        n_opri;
    logic                 exec;
    logic                 is_full;
    logic                 is_empty;
    mpq_pkg::t_cell_op    cell_op;
    logic [CntW+mpq_pkg::HeldW-1:0] held_ext;

    mpq_pkg::t_data       cell_data  [DEPTH];
    mpq_pkg::t_pri        cell_pri   [DEPTH];
    logic                 cell_shift [DEPTH];

    assign o_in_ready = !r_busy;
    assign exec       = r_busy && (!r_ovalid || i_out_ready);
    assign is_full    = (r_count == CntW'(DEPTH));
    assign is_empty   = (r_count == '0);

    always_comb begin
        cell_op  = mpq_pkg::CELL_HOLD;
        n_count  = r_count;
        n_status = mpq_pkg::ST_OK;
        n_odata  = '0;
        n_opri   = '0;
        unique case (r_act)
            mpq_pkg::ACT_INSERT: begin
                if (is_full) begin
                    n_status = mpq_pkg::ST_FULL;
                end else begin
                    cell_op = mpq_pkg::CELL_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            mpq_pkg::ACT_DELETE: begin
                if (is_empty) begin
                    n_status = mpq_pkg::ST_EMPTY;
                end else begin
                    cell_op = mpq_pkg::CELL_DELETE;
                    n_count = r_count - 1'b1;
                    n_odata = cell_data[0];
                    n_opri  = cell_pri[0];
                end
            end
            mpq_pkg::ACT_PEEK: begin
                if (is_empty) begin
                    n_status = mpq_pkg::ST_EMPTY;
                end else begin
                    n_odata = cell_data[0];
                    n_opri  = cell_pri[0];
                end
            end
            default: begin
                n_status = mpq_pkg::ST_OK;
            end
        endcase
        if (!exec) begin
            cell_op = mpq_pkg::CELL_HOLD;
            n_count = r_count;
        end
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        mpq_pkg::t_cell_ctl ctl;
        mpq_pkg::t_data     left_data;
        mpq_pkg::t_pri      left_pri;
        logic               left_shift;
        mpq_pkg::t_data     right_data;
        mpq_pkg::t_pri      right_pri;

        assign ctl.op       = cell_op;
        assign ctl.occupied = (CntW'(k) < r_count);
        assign ctl.tail     = (CntW'(k) == r_count);

        if (k == 0) begin : g_head
            assign left_data  = '0;
            assign left_pri   = '0;
            assign left_shift = 1'b0;
        end else begin : g_body
            assign left_data  = cell_data[k-1];
            assign left_pri   = cell_pri[k-1];
            assign left_shift = cell_shift[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            // Slot past the tail becomes free; its contents no longer matter.
            assign right_data = cell_data[k];
            assign right_pri  = cell_pri[k];
        end else begin : g_inner
            assign right_data = cell_data[k+1];
            assign right_pri  = cell_pri[k+1];
        end

        mpq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_new_data   (r_new_data),
            .i_new_pri    (r_new_pri),
            .i_left_data  (left_data),
            .i_left_pri   (left_pri),
            .i_left_shift (left_shift),
            .i_right_data (right_data),
            .i_right_pri  (right_pri),
            .o_data       (cell_data[k]),
            .o_pri        (cell_pri[k]),
            .o_shift      (cell_shift[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_busy <= 1'b1;
            end else if (exec) begin
                r_busy <= 1'b0;
            end
            r_count <= n_count;
            if (exec) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers: load on transfer or execution only.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_act      <= i_action;
            r_new_data <= i_new_data;
            r_new_pri  <= i_new_priority;
        end
        if (exec) begin
            r_status <= n_status;
            r_odata  <= n_odata;
            r_opri   <= n_opri;
        end
    end

    assign held_ext       = {{mpq_pkg::HeldW{1'b0}}, r_count};
    assign o_out_valid    = r_ovalid;
    assign o_status       = r_status;
    assign o_out_data     = r_odata;
    assign o_out_priority = r_opri;
    assign o_held_count   = held_ext[mpq_pkg::HeldW-1:0];

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("fill count above depth");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count > CntW'(1)) |-> (cell_pri[0] <= cell_pri[1]))
        else $error("chain head out of order");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && (n_status == mpq_pkg::ST_FULL)) |=> (r_count == CntW'(DEPTH)))
        else $error("full reported below depth");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && (n_status == mpq_pkg::ST_EMPTY)) |=> (r_count == '0))
        else $error("empty reported with entries held");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !exec |=> $stable(r_count))
        else $error("fill count moved without execution");
`endif

endmodule

// ===== sim/tb.sv =====
// Testbench for min_priority_queue: directed and random insert/delete/peek traffic,
// checked against an in-bench queue predictor. Depends on mpq_pkg and the queue RTL.
`timescale 1ns / 100ps

module tb;

    localparam int             QDEPTH      = 16;
    localparam int             CYCLE_LIMIT = 200000;
    localparam logic [1:0]     ACT_UNUSED  = 2'd3;
    localparam mpq_pkg::t_pri  PRI_MIN     = 32'sh8000_0000;
    localparam mpq_pkg::t_pri  PRI_MAX     = 32'sh7fff_ffff;

    typedef struct {
        logic [1:0]                status;
        mpq_pkg::t_data            data;
        mpq_pkg::t_pri             pri;
        logic [mpq_pkg::HeldW-1:0] held;
    } t_pq_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_action = mpq_pkg::ACT_INSERT;
    mpq_pkg::t_data            i_new_data = '0;
    mpq_pkg::t_pri             i_new_priority = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [1:0]                o_status;
    mpq_pkg::t_data            o_out_data;
    mpq_pkg::t_pri             o_out_priority;
    logic [mpq_pkg::HeldW-1:0] o_held_count;

    // queue predictor state: entries in arrival order
    mpq_pkg::t_data   queue_data [QDEPTH];
    mpq_pkg::t_pri    queue_pri [QDEPTH];
    int               queue_fill = 0;

    t_pq_result       pending_results [$];
    t_pq_result       oldest_result;
    bit               stall_en = 1'b1;
    int               error_count = 0;
    int               result_count = 0;
    int               cycle_count = 0;

    min_priority_queue #(.DEPTH(QDEPTH)) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_new_data     (i_new_data),
        .i_new_priority (i_new_priority),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_out_data     (o_out_data),
        .o_out_priority (o_out_priority),
        .o_held_count   (o_held_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Apply one command to the predictor and return the result it must produce.
    function automatic t_pq_result apply_queue_cmd(logic [1:0] act, mpq_pkg::t_data d,
                                                   mpq_pkg::t_pri p);
        t_pq_result r;
        int         best;
        int         k;
        r.status = mpq_pkg::ST_OK;
        r.data   = '0;
        r.pri    = '0;
        case (act)
            mpq_pkg::ACT_INSERT: begin
                if (queue_fill >= QDEPTH) begin
                    r.status = mpq_pkg::ST_FULL;
                end else begin
                    queue_data[queue_fill] = d;
                    queue_pri[queue_fill]  = p;
                    queue_fill++;
                end
            end
            mpq_pkg::ACT_DELETE, mpq_pkg::ACT_PEEK: begin
                if (queue_fill == 0) begin
                    r.status = mpq_pkg::ST_EMPTY;
                end else begin
                    // strict less-than keeps the oldest entry on a tie
                    best = 0;
                    for (k = 1; k < queue_fill; k++)
                        if (queue_pri[k] < queue_pri[best])
                            best = k;
                    r.data = queue_data[best];
                    r.pri  = queue_pri[best];
                    if (act == mpq_pkg::ACT_DELETE) begin
                        for (k = best; k + 1 < queue_fill; k++) begin
                            queue_data[k] = queue_data[k + 1];
                            queue_pri[k]  = queue_pri[k + 1];
                        end
                        queue_fill--;
                    end
                end
            end
            default: ;
        endcase
        r.held = queue_fill[mpq_pkg::HeldW-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: result %0d %s mismatch: got %h, want %h", result_count, field, got, want);
        error_count++;
    endtask

    // Result checker and receiver-side stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transfer", {30'd0, o_status}, '0);
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_status !== oldest_result.status)
                    report_mismatch("status", {30'd0, o_status}, {30'd0, oldest_result.status});
                if (o_out_data !== oldest_result.data)
                    report_mismatch("out_data", o_out_data, oldest_result.data);
                if (o_out_priority !== oldest_result.pri)
                    report_mismatch("out_priority", o_out_priority, oldest_result.pri);
                if (o_held_count !== oldest_result.held)
                    report_mismatch("held_count", {27'd0, o_held_count},
                                    {27'd0, oldest_result.held});
            end
            result_count++;
        end
        i_out_ready <= !(stall_en && ($urandom_range(0, 99) < 14));
    end

    // Drive one item and hold it until the transfer; valid stays high afterward.
    task automatic send_item(input logic [1:0] act, input mpq_pkg::t_data d,
                             input mpq_pkg::t_pri p);
        int gap;
        gap = 0;
        if (stall_en && ($urandom_range(0, 99) < 14))
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_new_data     <= d;
        i_new_priority <= p;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(apply_queue_cmd(act, d, p));
    endtask

    // Drop valid and hold off until every outstanding result has been checked.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic test_empty_queue();
        send_item(mpq_pkg::ACT_DELETE, 32'h7fff_ffff, PRI_MIN);
        send_item(mpq_pkg::ACT_PEEK, 32'h8000_0000, PRI_MAX);
        send_item(ACT_UNUSED, 32'hffff_ffff, 32'sh1234_5678);
    endtask

    task automatic test_fill_to_full();
        mpq_pkg::t_pri  pri_list [QDEPTH];
        mpq_pkg::t_data data_list [QDEPTH];
        int             n;
        pri_list = '{32'sd5, PRI_MAX, PRI_MIN, 32'sd0, 32'sd5, -32'sd1, PRI_MIN, PRI_MAX,
                     32'sd3, 32'sd5, 32'sd0, -32'sd1, 32'sd7, PRI_MIN, 32'sd2, 32'sd1};
        data_list = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                      32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444,
                      32'h5555_5555, 32'haaaa_aaaa, 32'h6666_6666, 32'h7777_7777,
                      32'h8888_8888, 32'h9999_9999, 32'hcccc_cccc, 32'hdddd_dddd};
        for (n = 0; n < QDEPTH; n++)
            send_item(mpq_pkg::ACT_INSERT, data_list[n], pri_list[n]);
        send_item(mpq_pkg::ACT_INSERT, $urandom, $urandom);
        send_item(mpq_pkg::ACT_PEEK, $urandom, $urandom);
        send_item(ACT_UNUSED, $urandom, $urandom);
        // three entries tie at the lowest priority: oldest must leave first
        send_item(mpq_pkg::ACT_DELETE, $urandom, $urandom);
        send_item(mpq_pkg::ACT_DELETE, $urandom, $urandom);
    endtask

    task automatic test_random_traffic(input int num_items);
        int            n;
        int            mode;
        int            roll;
        int            insert_pct;
        logic [1:0]    act;
        mpq_pkg::t_pri p;
        n = 0;
        mode = 0;
        while (n < num_items) begin
            if (n % 40 == 0)
                mode = $urandom_range(0, 2);
            insert_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                act = ACT_UNUSED;
            else if ($urandom_range(0, 99) < insert_pct)
                act = mpq_pkg::ACT_INSERT;
            else if ($urandom_range(0, 99) < 70)
                act = mpq_pkg::ACT_DELETE;
            else
                act = mpq_pkg::ACT_PEEK;
            roll = $urandom_range(0, 99);
            if (roll < 50)
                p = int'($urandom_range(0, 7)) - 4;     // narrow range forces ties
            else if (roll < 85)
                p = $urandom;
            else
                case ($urandom_range(0, 3))
                    0: p = PRI_MIN;
                    1: p = PRI_MAX;
                    2: p = '0;
                    default: p = -32'sd1;
                endcase
            send_item(act, $urandom, p);
            if (act != ACT_UNUSED) begin
                n++;
                if (n == num_items / 3)
                    drain_results();
                if (n == num_items / 2)
                    stall_en = 1'b0;
                if (n == (num_items * 3) / 4)
                    stall_en = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_queue();
        test_fill_to_full();
        test_random_traffic(450);
        drain_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mpq_pkg.sv
rtl/core/mpq_cell.sv
rtl/core/min_priority_queue.sv
sim/tb.sv
